/* design/assert_macros.svh */
// Assertion macros shared by the tone mapping RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("concurrent assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* design/aces_tm_pkg.sv */
// Shared constants and helpers for the ACES tone mapping pixel packer.
// No dependencies; imported by every module of the block.
`default_nettype none

package aces_tm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int LANES       = 3;
  localparam int COLOR_WIDTH = LANES * BYTE_WIDTH;
  // Quotient bits of the ratio divider: one more than a byte to see overflow.
  localparam int RATIO_BITS  = BYTE_WIDTH + 1;
  localparam logic [BYTE_WIDTH-1:0] MAX_BYTE = 8'hFF;

  // Curve coefficient given in hundredths, rounded to frac fraction bits.
  function automatic longint unsigned coef(input longint unsigned hundredths,
                                           input int frac);
    longint unsigned scaled;
    scaled = (hundredths << frac) + 64'd50;
    return scaled / 64'd100;
  endfunction

endpackage

`default_nettype wire

/* design/aces_tone_map_pixel_pack_unit.sv */
// Top level of the ACES tone mapping pixel packer: three channel lanes
// (aces_tm_avg, aces_tm_curve) and the packing stage. Uses aces_tm_pkg.
//
// Usage:
//   Command channel: a pixel transfer happens at a rising edge with start
//   high and busy low. busy is always low; a new pixel may be given every
//   cycle. red_sum, green_sum and blue_sum are unsigned fixed-point sums.
//   Result channel: done is high for one cycle with packed_color holding
//   0xRRGGBB. The receiver cannot stall, and no result is ever held back.
//   Configuration: cfg_write with cfg_wdata sets the sample count (zero acts
//   as one). Write it only while no pixel is in flight.
//   Throughput: one pixel per cycle. Each channel passes the divider that
//   averages it, which resolves one quotient bit per stage, then the ratio
//   divider of the curve at one bit per stage, then the packing register.
//   Reset: synchronous, active high; empties the pipeline and sets the
//   sample count to one.
`default_nettype none

module aces_tone_map_pixel_pack_unit
  import aces_tm_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int SUM_WIDTH     = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SUM_WIDTH-1:0]   red_sum,
  input  wire logic [SUM_WIDTH-1:0]   green_sum,
  input  wire logic [SUM_WIDTH-1:0]   blue_sum,
  input  wire logic                   cfg_write,
  input  wire logic [COUNT_WIDTH-1:0] cfg_wdata,
  output logic                        done,
  output logic [COLOR_WIDTH-1:0]      packed_color
);
`include "assert_macros.svh"

  localparam int LATENCY = SUM_WIDTH + RATIO_BITS + 5;

  logic [COUNT_WIDTH-1:0] sample_count;
  logic [COUNT_WIDTH-1:0] divisor;

  // Sample count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_WIDTH'(1);
    end else if (cfg_write) begin
      sample_count <= cfg_wdata;
    end
  end

  assign divisor = (sample_count == '0) ? COUNT_WIDTH'(1) : sample_count;
  assign busy    = 1'b0;

  logic [SUM_WIDTH-1:0]  lane_sum  [0:LANES-1];
  logic [SUM_WIDTH-1:0]  lane_x    [0:LANES-1];
  logic                  lane_xv   [0:LANES-1];
  logic [BYTE_WIDTH-1:0] lane_byte [0:LANES-1];
  logic                  lane_v    [0:LANES-1];

  assign lane_sum[0] = red_sum;
  assign lane_sum[1] = green_sum;
  assign lane_sum[2] = blue_sum;

  // One lane per color channel.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    aces_tm_avg #(
      .SUM_WIDTH(SUM_WIDTH)
    ) u_avg (
      .clk      (clk),
      .rst      (rst),
      .in_valid (start),
      .sum      (lane_sum[l]),
      .divisor  (divisor),
      .out_valid(lane_xv[l]),
      .quotient (lane_x[l])
    );

    aces_tm_curve #(
      .FRACTION_BITS(FRACTION_BITS),
      .SUM_WIDTH    (SUM_WIDTH)
    ) u_curve (
      .clk      (clk),
      .rst      (rst),
      .in_valid (lane_xv[l]),
      .x        (lane_x[l]),
      .out_valid(lane_v[l]),
      .tone     (lane_byte[l])
    );
  end

  // Merge the lane bytes into one packed result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_v[0];
    end
  end

  always_ff @(posedge clk) begin
    packed_color <= {lane_byte[0], lane_byte[1], lane_byte[2]};
  end

  `ASSERT_AT(a_lanes_aligned, clk, rst, (lane_v[0] == lane_v[1]) && (lane_v[1] == lane_v[2]))
  `ASSERT_AT(a_done_from_start, clk, rst, done |-> $past(start, LATENCY))
  `ASSERT_AT(a_black_red, clk, rst, (done && $past(red_sum == '0, LATENCY)) |-> (packed_color[COLOR_WIDTH-1 -: BYTE_WIDTH] == '0))

endmodule

`default_nettype wire

/* design/aces_tm_avg.sv */
// Pipelined restoring divider: averages one channel sum over the sample count.
// Depends on aces_tm_pkg; one quotient bit is resolved per pipeline stage.
`default_nettype none

module aces_tm_avg
  import aces_tm_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [SUM_WIDTH-1:0]   sum,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  output logic                        out_valid,
  output logic [SUM_WIDTH-1:0]        quotient
);

  logic [COUNT_WIDTH-1:0] rem  [0:SUM_WIDTH];
  logic [SUM_WIDTH-1:0]   word [0:SUM_WIDTH];
  logic                   vld  [0:SUM_WIDTH];

  // Stage zero input: empty remainder, whole dividend still to shift in.
  assign rem[0]  = '0;
  assign word[0] = sum;
  assign vld[0]  = in_valid;

  for (genvar k = 0; k < SUM_WIDTH; k++) begin : g_stage
    logic [COUNT_WIDTH:0]   trial;
    logic                   qbit;
    logic [COUNT_WIDTH:0]   diff;

    // Shift in the next dividend bit and try one subtraction.
    always_comb begin
      trial = {rem[k], word[k][SUM_WIDTH-1]};
      qbit  = (trial >= {1'b0, divisor});
      diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= qbit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      word[k+1] <= {word[k][SUM_WIDTH-2:0], qbit};
    end
  end

  assign out_valid = vld[SUM_WIDTH];
  assign quotient  = word[SUM_WIDTH];

endmodule

`default_nettype wire

/* design/aces_tm_curve.sv */
// Filmic curve for one channel: clamp, two multiply stages, then a
// pipelined ratio divider and byte saturation. Depends on aces_tm_pkg.
`default_nettype none

module aces_tm_curve
  import aces_tm_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int SUM_WIDTH     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [SUM_WIDTH-1:0]  x,
  output logic                       out_valid,
  output logic [BYTE_WIDTH-1:0]      tone
);
`include "assert_macros.svh"

  localparam int F   = FRACTION_BITS;
  localparam int XW  = F + 4;                 // clamped radiance, up to 8.0
  localparam int QW  = (SUM_WIDTH > XW) ? SUM_WIDTH : XW;
  localparam int PW  = XW + F + 2;            // coefficient times radiance
  localparam int SW  = F + 7;                 // bracket term
  localparam int TW  = XW + SW;               // second product
  localparam int NUMW = TW - F;               // numerator
  localparam int DW  = NUMW + 1;              // denominator
  localparam int RW  = DW + RATIO_BITS;       // ratio remainder

  localparam logic [F+1:0] COEF_A = (F+2)'(coef(64'd251, F));
  localparam logic [F-1:0] COEF_B = F'(coef(64'd3, F));
  localparam logic [F+1:0] COEF_C = (F+2)'(coef(64'd243, F));
  localparam logic [F-1:0] COEF_D = F'(coef(64'd59, F));
  localparam logic [F-1:0] COEF_E = F'(coef(64'd14, F));
  localparam logic [QW-1:0] X_LIMIT = QW'(8) << F;

  logic [QW-1:0] x_wide;
  logic [XW-1:0] xc;

  // Limit radiance to 8.0, where the curve has already reached one.
  always_comb begin
    x_wide = QW'(x);
    xc     = (x_wide > X_LIMIT) ? X_LIMIT[XW-1:0] : x_wide[XW-1:0];
  end

  // First multiply stage.
  logic          v1;
  logic [PW-1:0] pa;
  logic [PW-1:0] pc;
  logic [XW-1:0] x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pa <= PW'(COEF_A) * PW'(xc);
    pc <= PW'(COEF_C) * PW'(xc);
    x1 <= xc;
  end

  // Second multiply stage.
  logic          v2;
  logic [TW-1:0] tn;
  logic [TW-1:0] td;
  logic [SW-1:0] bn;
  logic [SW-1:0] bd;

  always_comb begin
    bn = SW'(pa >> F) + SW'(COEF_B);
    bd = SW'(pc >> F) + SW'(COEF_D);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    tn <= TW'(x1) * TW'(bn);
    td <= TW'(x1) * TW'(bd);
  end

  // Divider setup: numerator scaled by 256, overflow flag for ratios of two.
  logic [NUMW-1:0] num;
  logic [DW-1:0]   den;

  always_comb begin
    num = NUMW'(tn >> F);
    den = DW'(td >> F) + DW'(COEF_E);
  end

  logic [RW-1:0]         rem_s [0:RATIO_BITS];
  logic [DW-1:0]         den_s [0:RATIO_BITS];
  logic [RATIO_BITS-1:0] q_s   [0:RATIO_BITS];
  logic                  sat_s [0:RATIO_BITS];
  logic                  v_s   [0:RATIO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    rem_s[0] <= RW'(num) << BYTE_WIDTH;
    den_s[0] <= den;
    q_s[0]   <= '0;
    sat_s[0] <= ({1'b0, num} >= (den << 1));
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < RATIO_BITS; j++) begin : g_ratio
    localparam int SH = RATIO_BITS - 1 - j;
    logic [RW-1:0] dsh;
    logic          take;

    always_comb begin
      dsh  = RW'(den_s[j]) << SH;
      take = (rem_s[j] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_s[j+1]  <= take ? (rem_s[j] - dsh) : rem_s[j];
      den_s[j+1]  <= den_s[j];
      q_s[j+1]    <= q_s[j] | (RATIO_BITS'(take) << SH);
      sat_s[j+1]  <= sat_s[j];
    end
  end

  // Saturate the ratio to one byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_s[RATIO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (sat_s[RATIO_BITS] || q_s[RATIO_BITS][RATIO_BITS-1]) begin
      tone <= MAX_BYTE;
    end else begin
      tone <= q_s[RATIO_BITS][BYTE_WIDTH-1:0];
    end
  end

  `ASSERT_NEVER(a_den_nonzero, clk, rst, v_s[0] && (den_s[0] == '0))
  `ASSERT_AT(a_ratio_fits, clk, rst, (v_s[RATIO_BITS] && !sat_s[RATIO_BITS]) |-> (rem_s[RATIO_BITS] < RW'(den_s[RATIO_BITS])))

endmodule

`default_nettype wire

/* dv/aces_tone_map_pixel_pack_unit_test.sv */
// Self-checking testbench for the ACES tone mapping pixel packer.
// Depends on aces_tm_pkg and aces_tone_map_pixel_pack_unit; predicts each packed color.
`default_nettype none

module aces_tone_map_pixel_pack_unit_test;
  import aces_tm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 16;
  localparam int SUMW       = 32;
  localparam int LATENCY    = SUMW + 14;
  localparam int RANDOM_PIX = 1400;

  // One directed row: channel sums and, where obvious, the expected color.
  typedef struct {
    logic [SUMW-1:0]        red;
    logic [SUMW-1:0]        green;
    logic [SUMW-1:0]        blue;
    bit                     known;
    logic [COLOR_WIDTH-1:0] color;
  } pixel_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [SUMW-1:0]        red_sum;
  logic [SUMW-1:0]        green_sum;
  logic [SUMW-1:0]        blue_sum;
  logic                   cfg_write;
  logic [COUNT_WIDTH-1:0] cfg_wdata;
  logic                   done;
  logic [COLOR_WIDTH-1:0] packed_color;

  logic [COUNT_WIDTH-1:0] model_count;
  logic [COLOR_WIDTH-1:0] pending_colors[$];
  bit                     failed;
  bit                     table_failed;

  aces_tone_map_pixel_pack_unit #(.FRACTION_BITS(FRAC), .SUM_WIDTH(SUMW)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_sum(red_sum), .green_sum(green_sum), .blue_sum(blue_sum),
    .cfg_write(cfg_write), .cfg_wdata(cfg_wdata),
    .done(done), .packed_color(packed_color)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Filmic curve on one channel, scaled to a saturated byte.
  function automatic logic [7:0] filmic_byte(logic [SUMW-1:0] sum, logic [15:0] n);
    logic [63:0] x;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] div;
    div = (n == 16'd0) ? 64'd1 : 64'(n);
    x = 64'(sum) / div;
    if (x > (64'd8 << FRAC)) x = 64'd8 << FRAC;
    num = (x * (((64'd164495 * x) >> FRAC) + 64'd1966)) >> FRAC;
    den = ((x * (((64'd159252 * x) >> FRAC) + 64'd38666)) >> FRAC) + 64'd9175;
    q = (num << 8) / den;
    return (q > 64'd255) ? 8'hFF : q[7:0];
  endfunction

  function automatic logic [COLOR_WIDTH-1:0] tone_mapped_color(logic [SUMW-1:0] r,
      logic [SUMW-1:0] g, logic [SUMW-1:0] b);
    return {filmic_byte(r, model_count), filmic_byte(g, model_count),
            filmic_byte(b, model_count)};
  endfunction

  // Drive one pixel after a gap of the given length, and record what it must produce.
  task automatic send_pixel(logic [SUMW-1:0] r, logic [SUMW-1:0] g, logic [SUMW-1:0] b,
      bit known, logic [COLOR_WIDTH-1:0] color, int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    red_sum   <= r;
    green_sum <= g;
    blue_sum  <= b;
    if (known && color != tone_mapped_color(r, g, b)) begin
      $error("table row disagrees with predictor: expected %h predicted %h",
             color, tone_mapped_color(r, g, b));
      table_failed = 1'b1;
    end
    pending_colors.insert(pending_colors.size(), known ? color : tone_mapped_color(r, g, b));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain the pipeline, then let the latency pass before a register write.
  task automatic set_sample_count(logic [15:0] n);
    start <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= n;
    model_count = n;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SUMW-1:0] random_sum(logic [15:0] n);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 3)) * (32'hFFFFFFFF >> $urandom_range(0, 31));
      2: return 32'(64'($urandom_range(0, 8 << FRAC)) * ((n == 0) ? 1 : n));
      3: return {16'd0, 16'($urandom())};
      default: return 32'($urandom_range(0, 4 << FRAC)) * ((n == 0) ? 1 : n);
    endcase
  endfunction

  // Each color transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_colors.size() == 0) begin
        $error("packed_color: no pixel pending, actual %h", packed_color);
        failed <= 1'b1;
      end else begin
        if (packed_color !== pending_colors[0]) begin
          $error("packed_color: expected %h actual %h", pending_colors[0], packed_color);
          failed <= 1'b1;
        end
        pending_colors.delete(0);
      end
    end
  end

  initial begin
    #50ms;
    $display("[aces_tone_map_pixel_pack_unit] ERROR");
    $finish;
  end

  initial begin
    pixel_row_t rows[$];
    logic [15:0] counts[$];
    int burst;
    int waited;
    table_failed = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    red_sum   = '0;
    green_sum = '0;
    blue_sum  = '0;
    cfg_write = 1'b0;
    cfg_wdata = '0;
    model_count = 16'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: zero, saturation, the one-point mark and all-ones sums.
    rows = '{
      '{32'd0, 32'd0, 32'd0, 1'b1, 24'h000000},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF},
      '{32'h00080000, 32'd0, 32'hFFFFFFFF, 1'b1, 24'hFF00FF},
      '{32'd0, 32'h00200000, 32'd0, 1'b1, 24'h00FF00},
      '{32'h00010000, 32'h00008000, 32'h00000001, 1'b0, 24'h000000},
      '{32'h00004000, 32'h00028000, 32'h0007FFFF, 1'b0, 24'h000000},
      '{32'h55555555, 32'hAAAAAAAA, 32'h00001000, 1'b0, 24'h000000}
    };
    counts = '{16'd1, 16'd0, 16'hFFFF, 16'd3};
    foreach (counts[c]) begin
      if (c != 0) set_sample_count(counts[c]);
      foreach (rows[i])
        send_pixel(rows[i].red, rows[i].green, rows[i].blue,
                   rows[i].known && counts[c] <= 16'd1, rows[i].color, 0);
    end

    // Random part in bursts, over several sample counts including the extremes.
    counts = '{16'd1, 16'd0, 16'hFFFF, 16'd16, 16'd256, 16'd1024, 16'd7};
    foreach (counts[c]) begin
      set_sample_count(counts[c] == 16'd7 ? 16'($urandom()) : counts[c]);
      for (int k = 0; k < RANDOM_PIX / 7; ) begin
        burst = $urandom_range(1, 40);
        for (int j = 0; j < burst; j++, k++)
          send_pixel(random_sum(model_count), random_sum(model_count),
                     random_sum(model_count), 1'b0, '0,
                     (j == 0) ? $urandom_range(0, 12) : 0);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_colors.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (!failed && !table_failed && pending_colors.size() == 0) begin
      $display("[aces_tone_map_pixel_pack_unit] OK");
    end else begin
      $display("[aces_tone_map_pixel_pack_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
